// ===== design/ffba_pkg.sv =====
// Shared types and codes of the first-fit block allocator.
package ffba_pkg;

    localparam int CMD_BITS  = 2;
    localparam int SIZE_BITS = 8;
    localparam int STAT_BITS = 3;
    localparam int CFG_BITS  = 8;

    localparam logic [CMD_BITS-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DEFRAG = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_ALLOC_OK   = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_ALLOC_FAIL = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_ERASE_OK   = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_ERASE_BAD  = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_DEFRAG     = 3'd4;

    localparam logic [CFG_BITS-1:0] CELLS_RESET = 8'd128;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic fill;
        logic tail;
        logic put;
    } t_dp_cmd;

    // Conditions reported by the datapath.
    typedef struct packed {
        logic clear_last;
        logic found;
        logic scan_end;
        logic fill_last;
        logic tail_end;
        logic out_free;
        logic is_defrag;
    } t_dp_sts;

endpackage

// ===== design/ffba_ctrl.sv =====
// Sequencer of the first-fit block allocator: clear, scan, fill, tail and result phases.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FILL  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_FILL;
                end else if (i_sts.scan_end) begin
                    n_state = i_sts.is_defrag ? S_TAIL : S_DONE;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                if (i_sts.tail_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register has room
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/ffba_dp.sv =====
// Datapath of the first-fit block allocator: cell owner memory, scan counters, handle counter.
module ffba_dp
    import ffba_pkg::*;
#(
    parameter int CELLS       = 128,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_BITS-1:0]    i_cfg_data,
    input  logic [CMD_BITS-1:0]    i_command,
    input  logic [SIZE_BITS-1:0]   i_alloc_size,
    input  logic [HANDLE_BITS-1:0] i_handle_in,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [STAT_BITS-1:0]   o_status,
    output logic [HANDLE_BITS-1:0] o_handle_out
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW = $clog2(CELLS + 1);
    localparam logic [CW-1:0] NCELLS    = CW'(CELLS);
    localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
    localparam logic [HANDLE_BITS-1:0] HMAX = {HANDLE_BITS{1'b1}};
    localparam logic [HANDLE_BITS-1:0] HFIRST = HANDLE_BITS'(1);

    logic [HANDLE_BITS-1:0] r_mem [CELLS];
    logic [HANDLE_BITS-1:0] r_rdata;

    logic [CFG_BITS-1:0]    r_cells;
    logic [CMD_BITS-1:0]    r_cmd;
    logic [SIZE_BITS-1:0]   r_size;
    logic [HANDLE_BITS-1:0] r_hin;
    logic [CW-1:0]          r_idx;
    logic [AW-1:0]          r_pidx;
    logic                   r_pvld;
    logic [SIZE_BITS-1:0]   r_run;
    logic                   r_found;
    logic                   r_live;
    logic [CW-1:0]          r_dst;
    logic [AW-1:0]          r_faddr;
    logic [SIZE_BITS-1:0]   r_fleft;
    logic [HANDLE_BITS-1:0] r_next;
    logic                   r_exh;
    logic [HANDLE_BITS-1:0] r_given;
    logic                   r_ovld;
    logic [STAT_BITS-1:0]   r_status;
    logic [HANDLE_BITS-1:0] r_hout;

    logic [CW-1:0]          ncells;
    logic                   issue;
    logic                   is_alloc;
    logic                   is_erase;
    logic                   is_defrag;
    logic [SIZE_BITS-1:0]   run_n;
    logic                   found;
    logic                   hit;
    logic                   keep;
    logic                   tail_end;
    logic                   out_free;
    logic                   we;
    logic [AW-1:0]          wa;
    logic [HANDLE_BITS-1:0] wd;
    logic [STAT_BITS-1:0]   res_status;
    logic [HANDLE_BITS-1:0] res_handle;

    // Cells in use: the register clipped to the memory depth.
    assign ncells    = (32'(r_cells) > 32'(CELLS)) ? NCELLS : CW'(r_cells);
    assign issue     = (r_idx < ncells);
    assign is_alloc  = (r_cmd == CMD_ALLOC);
    assign is_erase  = (r_cmd == CMD_ERASE);
    assign is_defrag = !is_alloc && !is_erase;
    assign run_n     = (r_rdata == '0) ? (r_run + SIZE_BITS'(1)) : '0;
    assign found     = i_cmd.scan && r_pvld && is_alloc && !r_found && (r_size != '0)
                       && !r_exh && (run_n == r_size);
    assign hit       = r_pvld && is_erase && (r_hin != '0) && (r_rdata == r_hin);
    assign keep      = r_pvld && is_defrag && (r_rdata != '0);
    assign tail_end  = (r_dst >= ncells);
    assign out_free  = !r_ovld || !i_out_stall;

    always_comb begin
        we = 1'b0;
        wa = r_pidx;
        wd = '0;
        if (i_cmd.clear) begin
            we = 1'b1;
            wa = r_idx[AW-1:0];
        end else if (i_cmd.scan) begin
            if (hit) begin
                we = 1'b1;
                wa = r_pidx;
            end else if (keep) begin
                // pack behind the read pointer; never overtakes it
                we = 1'b1;
                wa = r_dst[AW-1:0];
                wd = r_rdata;
            end
        end else if (i_cmd.fill) begin
            we = 1'b1;
            wa = r_faddr;
            wd = r_next;
        end else if (i_cmd.tail && !tail_end) begin
            we = 1'b1;
            wa = r_dst[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_cmd.scan && issue) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_comb begin
        case (r_cmd)
            CMD_ALLOC: res_status = r_found ? ST_ALLOC_OK : ST_ALLOC_FAIL;
            CMD_ERASE: res_status = r_live ? ST_ERASE_OK : ST_ERASE_BAD;
            default:   res_status = ST_DEFRAG;
        endcase
        res_handle = (is_alloc && r_found) ? r_given : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= CELLS_RESET;
            r_idx   <= '0;
            r_pvld  <= 1'b0;
            r_found <= 1'b0;
            r_live  <= 1'b0;
            r_dst   <= '0;
            r_next  <= HFIRST;
            r_exh   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cells <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.load) begin
                r_cmd   <= i_command;
                r_size  <= i_alloc_size;
                r_hin   <= i_handle_in;
                r_idx   <= '0;
                r_pvld  <= 1'b0;
                r_run   <= '0;
                r_found <= 1'b0;
                r_live  <= 1'b0;
                r_dst   <= '0;
            end
            if (i_cmd.scan) begin
                r_pvld <= issue;
                r_pidx <= r_idx[AW-1:0];
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_pvld) begin
                    r_run <= run_n;
                end
                if (found) begin
                    r_found <= 1'b1;
                    r_faddr <= r_pidx;
                    r_fleft <= r_size - SIZE_BITS'(1);
                    r_given <= r_next;
                end
                if (hit) begin
                    r_live <= 1'b1;
                end
                if (keep) begin
                    r_dst <= r_dst + CW'(1);
                end
            end
            if (i_cmd.fill) begin
                r_faddr <= r_faddr - AW'(1);
                r_fleft <= r_fleft - SIZE_BITS'(1);
                if (r_fleft == '0) begin
                    // saturate at the largest handle
                    if (r_next == HMAX) begin
                        r_exh <= 1'b1;
                    end else begin
                        r_next <= r_next + HFIRST;
                    end
                end
            end
            if (i_cmd.tail && !tail_end) begin
                r_dst <= r_dst + CW'(1);
            end
            if (i_cmd.put) begin
                r_ovld   <= 1'b1;
                r_status <= res_status;
                r_hout   <= res_handle;
            end else if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_idx == LAST_CELL);
    assign o_sts.found      = found;
    assign o_sts.scan_end   = !issue && !r_pvld;
    assign o_sts.fill_last  = (r_fleft == '0);
    assign o_sts.tail_end   = tail_end;
    assign o_sts.out_free   = out_free;
    assign o_sts.is_defrag  = is_defrag;

    assign o_out_valid  = r_ovld;
    assign o_status     = r_status;
    assign o_handle_out = r_hout;

endmodule

// ===== design/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator with compaction.
//
// The block keeps a memory of CELLS cells, each free (owner 0) or owned by a
// block handle, and takes one command word at a time: allocate finds the first
// run of alloc_size free cells among the first memory_cells cells and marks it
// with the next handle (1, 2, ... up to the largest HANDLE_BITS value, then
// allocate fails), erase frees every cell of a live handle, defragment packs
// the used cells to the front in order. Each command word returns one status
// word. After reset the owner memory is swept to zero, one cell per cycle,
// with input stalled; configuration writes are taken during that sweep.
// Commands run one at a time, each a walk over the owner memory through its
// single read port and single write port across the first min(memory_cells,
// CELLS) cells; allocate stops at the first fitting run and writes it with its
// handle, and defragment afterwards clears the cells behind the packed ones.
// The result sits in an output register, so the next command word is accepted
// while an earlier status word still waits on i_out_stall. Write memory_cells
// only while no command is in flight.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int CELLS       = 128,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: memory_cells
    input  logic                   i_cfg_we,
    input  logic [CFG_BITS-1:0]    i_cfg_data,
    // command words
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CMD_BITS-1:0]    i_command,
    input  logic [SIZE_BITS-1:0]   i_alloc_size,
    input  logic [HANDLE_BITS-1:0] i_handle_in,
    // status words
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STAT_BITS-1:0]   o_status,
    output logic [HANDLE_BITS-1:0] o_handle_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Controller: walk the phases, accept a command word only when idle.
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Datapath: owner memory, run counter, pack pointer, handle counter, output register.
    ffba_dp #(
        .CELLS       (CELLS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_alloc_size (i_alloc_size),
        .i_handle_in  (i_handle_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_handle_out (o_handle_out)
    );

endmodule

// ===== design/ffba_chk.sv =====
// Port checker of the first-fit block allocator and its bind.
module ffba_chk
    import ffba_pkg::*;
#(
    parameter int HANDLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_we,
    input logic [CFG_BITS-1:0]    i_cfg_data,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic [CMD_BITS-1:0]    i_command,
    input logic [SIZE_BITS-1:0]   i_alloc_size,
    input logic [HANDLE_BITS-1:0] i_handle_in,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [STAT_BITS-1:0]   o_status,
    input logic [HANDLE_BITS-1:0] o_handle_out
);

    // a stalled status word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_handle_out))
        else $error("status word changed under stall");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_DEFRAG))
        else $error("status code out of range");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_ALLOC_OK) |-> (o_handle_out == '0))
        else $error("handle given without a successful allocate");

    a_handle_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ALLOC_OK) |-> (o_handle_out != '0))
        else $error("successful allocate gave handle zero");

    // one command at a time: stall right after an accepted word
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command word accepted back to back");

endmodule

bind first_fit_block_allocator ffba_chk #(.HANDLE_BITS(HANDLE_BITS)) u_ffba_chk (.*);
